/* rtl/hidkb_pkg.sv */
package hidkb_pkg;

  localparam int unsigned BITMAP_BYTES_DEF = 28;
  localparam int unsigned BOOT_SLOTS_DEF   = 6;
  localparam int unsigned KEY_BYTES        = 28;
  localparam int unsigned CNT_W            = 5;
  localparam int unsigned STEP_W           = 5;
  localparam int unsigned LSHIFT_BIT       = 1;

  localparam logic [2:0] CMD_PRESS_CHR = 3'd0;
  localparam logic [2:0] CMD_REL_CHR   = 3'd1;
  localparam logic [2:0] CMD_TYPE_CHR  = 3'd2;
  localparam logic [2:0] CMD_REL_ALL   = 3'd3;
  localparam logic [2:0] CMD_PRESS_USE = 3'd4;
  localparam logic [2:0] CMD_REL_USE   = 3'd5;

  localparam logic [7:0] MOD_CODE_LO = 8'd128;
  localparam logic [7:0] MOD_CODE_HI = 8'd135;
  localparam logic [7:0] USE_MOD_LO  = 8'hE0;
  localparam logic [7:0] USE_MOD_HI  = 8'hE7;
  localparam logic [7:0] USE_KEY_HI  = 8'hDF;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_RMW_RD,
    OP_UPDATE,
    OP_CLEAR,
    OP_HALF,
    OP_EMIT_MOD,
    OP_EMIT_BM,
    OP_EMIT_ZERO,
    OP_EMIT_SLOT,
    OP_EMIT_ERR,
    OP_SC_BIT,
    OP_SC_LOAD
  } op_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ACC,
    C_BAD_CMD,
    C_REL_ALL,
    C_UNDEC_REL,
    C_UNDEC_PRESS,
    C_BOOT,
    C_BM_MORE,
    C_TYPE,
    C_SC_BUSY,
    C_SC_MORE,
    C_SLOT_MORE
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic       ok;
    logic       shifted;
    logic [7:0] usage;
  } dec_t;

  typedef struct packed {
    logic             clr;
    logic             we;
    logic [CNT_W-1:0] waddr;
    logic [7:0]       wdata;
    logic [CNT_W-1:0] raddr;
  } km_ctrl_t;

  localparam logic [STEP_W-1:0] S_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] S_DISP     = 5'd1;
  localparam logic [STEP_W-1:0] S_DISP2    = 5'd2;
  localparam logic [STEP_W-1:0] S_CHK      = 5'd3;
  localparam logic [STEP_W-1:0] S_CHK2     = 5'd4;
  localparam logic [STEP_W-1:0] S_RMW      = 5'd5;
  localparam logic [STEP_W-1:0] S_UPD      = 5'd6;
  localparam logic [STEP_W-1:0] S_REPORT   = 5'd7;
  localparam logic [STEP_W-1:0] S_BM       = 5'd8;
  localparam logic [STEP_W-1:0] S_DONE     = 5'd9;
  localparam logic [STEP_W-1:0] S_DONE2    = 5'd10;
  localparam logic [STEP_W-1:0] S_ERR      = 5'd11;
  localparam logic [STEP_W-1:0] S_RELALL   = 5'd12;
  localparam logic [STEP_W-1:0] S_SC_BIT   = 5'd13;
  localparam logic [STEP_W-1:0] S_SC_LOAD  = 5'd14;
  localparam logic [STEP_W-1:0] S_ZERO     = 5'd15;
  localparam logic [STEP_W-1:0] S_SLOT     = 5'd16;
  localparam logic [STEP_W-1:0] S_SLOT_END = 5'd17;

  // ASCII to usage; shifted marks characters that need left shift
  function automatic dec_t decode_char(logic [7:0] c);
    dec_t d;
    d.ok      = 1'b1;
    d.shifted = 1'b0;
    d.usage   = 8'h00;
    if (c inside {[8'h61:8'h7A]}) begin
      d.usage = c - 8'h61 + 8'h04;
    end else if (c inside {[8'h41:8'h5A]}) begin
      d.usage   = c - 8'h41 + 8'h04;
      d.shifted = 1'b1;
    end else if (c inside {[8'h31:8'h39]}) begin
      d.usage = c - 8'h31 + 8'h1E;
    end else begin
      case (c)
        8'h30: d.usage = 8'h27;
        8'h20: d.usage = 8'h2C;
        8'h2D: d.usage = 8'h2D;
        8'h3D: d.usage = 8'h2E;
        8'h5B: d.usage = 8'h2F;
        8'h5D: d.usage = 8'h30;
        8'h5C: d.usage = 8'h31;
        8'h3B: d.usage = 8'h33;
        8'h27: d.usage = 8'h34;
        8'h60: d.usage = 8'h35;
        8'h2C: d.usage = 8'h36;
        8'h2E: d.usage = 8'h37;
        8'h2F: d.usage = 8'h38;
        8'h0A: d.usage = 8'h28;
        8'h09: d.usage = 8'h2B;
        8'h21: begin d.usage = 8'h1E; d.shifted = 1'b1; end
        8'h40: begin d.usage = 8'h1F; d.shifted = 1'b1; end
        8'h23: begin d.usage = 8'h20; d.shifted = 1'b1; end
        8'h24: begin d.usage = 8'h21; d.shifted = 1'b1; end
        8'h25: begin d.usage = 8'h22; d.shifted = 1'b1; end
        8'h5E: begin d.usage = 8'h23; d.shifted = 1'b1; end
        8'h26: begin d.usage = 8'h24; d.shifted = 1'b1; end
        8'h2A: begin d.usage = 8'h25; d.shifted = 1'b1; end
        8'h28: begin d.usage = 8'h26; d.shifted = 1'b1; end
        8'h29: begin d.usage = 8'h27; d.shifted = 1'b1; end
        8'h5F: begin d.usage = 8'h2D; d.shifted = 1'b1; end
        8'h2B: begin d.usage = 8'h2E; d.shifted = 1'b1; end
        8'h7B: begin d.usage = 8'h2F; d.shifted = 1'b1; end
        8'h7D: begin d.usage = 8'h30; d.shifted = 1'b1; end
        8'h7C: begin d.usage = 8'h31; d.shifted = 1'b1; end
        8'h3A: begin d.usage = 8'h33; d.shifted = 1'b1; end
        8'h22: begin d.usage = 8'h34; d.shifted = 1'b1; end
        8'h7E: begin d.usage = 8'h35; d.shifted = 1'b1; end
        8'h3C: begin d.usage = 8'h36; d.shifted = 1'b1; end
        8'h3E: begin d.usage = 8'h37; d.shifted = 1'b1; end
        8'h3F: begin d.usage = 8'h38; d.shifted = 1'b1; end
        default: d.ok = 1'b0;
      endcase
    end
    return d;
  endfunction

  // control store: op, jump condition, jump target; fall through to step + 1
  function automatic ucw_t ucode(logic [STEP_W-1:0] s);
    ucw_t w;
    case (s)
      S_IDLE:     w = '{OP_ACCEPT,    C_NO_ACC,      S_IDLE};
      S_DISP:     w = '{OP_NOP,       C_BAD_CMD,     S_IDLE};
      S_DISP2:    w = '{OP_NOP,       C_REL_ALL,     S_RELALL};
      S_CHK:      w = '{OP_NOP,       C_UNDEC_REL,   S_IDLE};
      S_CHK2:     w = '{OP_NOP,       C_UNDEC_PRESS, S_ERR};
      S_RMW:      w = '{OP_RMW_RD,    C_NEVER,       S_IDLE};
      S_UPD:      w = '{OP_UPDATE,    C_NEVER,       S_IDLE};
      S_REPORT:   w = '{OP_EMIT_MOD,  C_BOOT,        S_SC_LOAD};
      S_BM:       w = '{OP_EMIT_BM,   C_BM_MORE,     S_BM};
      S_DONE:     w = '{OP_HALF,      C_TYPE,        S_CHK};
      S_DONE2:    w = '{OP_NOP,       C_ALWAYS,      S_IDLE};
      S_ERR:      w = '{OP_EMIT_ERR,  C_ALWAYS,      S_IDLE};
      S_RELALL:   w = '{OP_CLEAR,     C_ALWAYS,      S_REPORT};
      S_SC_BIT:   w = '{OP_SC_BIT,    C_SC_BUSY,     S_SC_BIT};
      S_SC_LOAD:  w = '{OP_SC_LOAD,   C_SC_MORE,     S_SC_BIT};
      S_ZERO:     w = '{OP_EMIT_ZERO, C_NEVER,       S_IDLE};
      S_SLOT:     w = '{OP_EMIT_SLOT, C_SLOT_MORE,   S_SLOT};
      S_SLOT_END: w = '{OP_NOP,       C_ALWAYS,      S_DONE};
      default:    w = '{OP_NOP,       C_ALWAYS,      S_IDLE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/hidkb_keymem.sv */
module hidkb_keymem import hidkb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  km_ctrl_t   ctrl_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]           mem_q [KEY_BYTES];
  logic [KEY_BYTES-1:0] vld_q;
  logic [7:0]           rd_q;
  logic                 rd_vld_q;
  logic                 rd_in_range;

  assign rd_in_range = ctrl_i.raddr < CNT_W'(KEY_BYTES);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.we) begin
      mem_q[ctrl_i.waddr] <= ctrl_i.wdata;
    end
    if (rd_in_range) begin
      rd_q <= mem_q[ctrl_i.raddr];
    end
  end

  // entries never written since reset or release-all read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        vld_q <= '0;
      end else if (ctrl_i.we) begin
        vld_q[ctrl_i.waddr] <= 1'b1;
      end
      rd_vld_q <= rd_in_range && vld_q[ctrl_i.raddr];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : 8'h00;

endmodule

/* rtl/hid_keyboard_report_engine_top.sv */
// channel | signals                             | word
// --------+-------------------------------------+------------------------------------------
// in      | in_valid_i / in_ready_o             | cmd_i, key_i
// out     | out_valid_o / out_ready_i           | report_byte_o, byte_index_o, boot_format_o,
//         |                                     | last_byte_o, write_error_o
// cfg     | cfg_we_i                            | cfg_wdata_i (boot_mode)
//
// One event at a time; in_ready_o is high only in the idle step.
// Bitmap report: one word per cycle while the output is not stalled.
// Boot report: the key memory scan takes a load step and a bit step per byte of 28,
// one more bit step per further key found in the same byte, and a last load to finish; it stops at BOOT_SLOTS keys.
// A type event repeats update and report for the release.
// Reset clears modifiers, key bitmap (valid bits) and boot_mode at once; no clearing pass.
// Output stalls hold the step counter only on word steps; the scan runs on under a stall,
// and the output register lets the block go idle with the last word still waiting.
module hid_keyboard_report_engine_top import hidkb_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF,
  parameter int unsigned BOOT_SLOTS   = BOOT_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [7:0] key_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] report_byte_o,
  output logic [4:0] byte_index_o,
  output logic       boot_format_o,
  output logic       last_byte_o,
  output logic       write_error_o
);

  localparam int unsigned N_W        = $clog2(BOOT_SLOTS + 1);
  localparam int unsigned SLOT_IDX_W = (BOOT_SLOTS > 1) ? $clog2(BOOT_SLOTS) : 1;
  localparam logic [N_W-1:0]   SLOTS_N   = N_W'(BOOT_SLOTS);
  localparam logic [CNT_W-1:0] BM_LAST   = CNT_W'(BITMAP_BYTES - 1);
  localparam logic [CNT_W-1:0] SLOT_LAST = CNT_W'(BOOT_SLOTS - 1);
  localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(KEY_BYTES);

  logic [STEP_W-1:0] step_q, step_d;
  logic [2:0]        cmd_q, cmd_d;
  logic [7:0]        key_q, key_d;
  logic              down_q, down_d;
  logic              type_q, type_d;
  logic [7:0]        mod_q, mod_d;
  logic              boot_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [N_W-1:0]    n_q, n_d;
  logic [7:0]        work_q, work_d;
  logic [7:0]        slot_q [BOOT_SLOTS];

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [4:0]        out_idx_q, out_idx_d;
  logic              out_boot_q, out_boot_d;
  logic              out_last_q, out_last_d;
  logic              out_err_q, out_err_d;

  ucw_t              uw;
  dec_t              chr, dec;
  km_ctrl_t          km;
  logic [7:0]        km_rd;
  logic              is_chr, acc, can_load, is_emit, load, cond_hit;
  logic              take, sc_busy;
  logic [7:0]        work_clr;
  logic [2:0]        low_idx;

  hidkb_keymem u_keymem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (km),
    .rd_data_o (km_rd)
  );

  assign in_ready_o = (step_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;

  // key decode
  always_comb begin
    chr       = decode_char(key_q);
    is_chr    = cmd_q inside {CMD_PRESS_CHR, CMD_REL_CHR, CMD_TYPE_CHR};
    dec.ok      = 1'b1;
    dec.shifted = 1'b0;
    dec.usage   = key_q;
    if (is_chr) begin
      if (key_q inside {[MOD_CODE_LO:MOD_CODE_HI]}) begin
        dec.usage = USE_MOD_LO + (key_q - MOD_CODE_LO);
      end else begin
        dec = chr;
      end
    end
  end

  // lowest set bit of the scan byte
  always_comb begin
    low_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (work_q[i]) begin
        low_idx = 3'(i);
      end
    end
  end

  assign work_clr = work_q & (work_q - 8'd1);
  assign take     = (work_q != 8'h00) && (n_q != SLOTS_N);
  assign sc_busy  = (work_clr != 8'h00) && ((n_q + N_W'(1)) != SLOTS_N);

  always_comb begin
    uw       = ucode(step_q);
    can_load = !out_valid_q || out_ready_i;
    is_emit  = uw.op inside {OP_EMIT_MOD, OP_EMIT_BM, OP_EMIT_ZERO, OP_EMIT_SLOT, OP_EMIT_ERR};
    load     = is_emit && can_load;

    case (uw.cond)
      C_NEVER:       cond_hit = 1'b0;
      C_ALWAYS:      cond_hit = 1'b1;
      C_NO_ACC:      cond_hit = !acc;
      C_BAD_CMD:     cond_hit = !(cmd_q inside {[CMD_PRESS_CHR:CMD_REL_USE]});
      C_REL_ALL:     cond_hit = (cmd_q == CMD_REL_ALL);
      C_UNDEC_REL:   cond_hit = is_chr && !dec.ok && !down_q;
      C_UNDEC_PRESS: cond_hit = is_chr && !dec.ok && down_q;
      C_BOOT:        cond_hit = boot_q;
      C_BM_MORE:     cond_hit = (cnt_q != BM_LAST);
      C_TYPE:        cond_hit = type_q;
      C_SC_BUSY:     cond_hit = sc_busy;
      C_SC_MORE:     cond_hit = (cnt_q != SCAN_END) && (n_q != SLOTS_N);
      C_SLOT_MORE:   cond_hit = (cnt_q != SLOT_LAST);
      default:       cond_hit = 1'b0;
    endcase

    if (is_emit && !can_load) begin
      step_d = step_q;
    end else if (cond_hit) begin
      step_d = uw.target;
    end else begin
      step_d = step_q + STEP_W'(1);
    end

    cmd_d      = cmd_q;
    key_d      = key_q;
    down_d     = down_q;
    type_d     = type_q;
    mod_d      = mod_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    work_d     = work_q;
    km         = '0;
    out_byte_d = 8'h00;
    out_idx_d  = 5'd0;
    out_boot_d = boot_q;
    out_last_d = 1'b0;
    out_err_d  = 1'b0;

    case (uw.op)
      OP_ACCEPT: begin
        if (acc) begin
          cmd_d  = cmd_i;
          key_d  = key_i;
          down_d = cmd_i inside {CMD_PRESS_CHR, CMD_TYPE_CHR, CMD_PRESS_USE};
          type_d = (cmd_i == CMD_TYPE_CHR);
        end
      end
      OP_UPDATE: begin
        if (dec.shifted) begin
          mod_d[LSHIFT_BIT] = down_q;
        end
        if (dec.usage inside {[USE_MOD_LO:USE_MOD_HI]}) begin
          mod_d[dec.usage[2:0]] = down_q;
        end else if (dec.usage <= USE_KEY_HI) begin
          km.we                    = 1'b1;
          km.waddr                 = dec.usage[7:3];
          km.wdata                 = km_rd;
          km.wdata[dec.usage[2:0]] = down_q;
        end
      end
      OP_CLEAR: begin
        mod_d  = 8'h00;
        km.clr = 1'b1;
      end
      OP_HALF: begin
        if (type_q) begin
          type_d = 1'b0;
          down_d = 1'b0;
        end
      end
      OP_EMIT_MOD: begin
        out_byte_d = mod_q;
        cnt_d      = '0;
        n_d        = '0;
      end
      OP_EMIT_BM: begin
        out_byte_d = km_rd;
        out_idx_d  = cnt_q + CNT_W'(1);
        out_last_d = (cnt_q == BM_LAST);
        if (load) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_EMIT_ZERO: begin
        out_idx_d = 5'd1;
        if (load) begin
          cnt_d = '0;
        end
      end
      OP_EMIT_SLOT: begin
        out_byte_d = slot_q[cnt_q[SLOT_IDX_W-1:0]];
        out_idx_d  = cnt_q + CNT_W'(2);
        out_last_d = (cnt_q == SLOT_LAST);
        if (load) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_EMIT_ERR: begin
        out_boot_d = 1'b0;
        out_last_d = 1'b1;
        out_err_d  = 1'b1;
      end
      OP_SC_BIT: begin
        if (take) begin
          n_d    = n_q + N_W'(1);
          work_d = work_clr;
        end
        if (!sc_busy) begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      OP_SC_LOAD: begin
        // usage 0 is not a key
        work_d = km_rd & ((cnt_q == '0) ? 8'hFE : 8'hFF);
      end
      default: begin
      end
    endcase

    // read port follows the next byte count, so data lines up with cnt_q
    if (uw.op == OP_RMW_RD) begin
      km.raddr = dec.usage[7:3];
    end else begin
      km.raddr = cnt_d;
    end

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      down_q      <= 1'b0;
      type_q      <= 1'b0;
      mod_q       <= 8'h00;
      boot_q      <= 1'b0;
      cnt_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      down_q      <= down_d;
      type_q      <= type_d;
      mod_q       <= mod_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        boot_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    work_q <= work_d;
    if (load) begin
      out_byte_q <= out_byte_d;
      out_idx_q  <= out_idx_d;
      out_boot_q <= out_boot_d;
      out_last_q <= out_last_d;
      out_err_q  <= out_err_d;
    end
    if (uw.op == OP_EMIT_MOD) begin
      for (int i = 0; i < BOOT_SLOTS; i++) begin
        slot_q[i] <= 8'h00;
      end
    end else if (uw.op == OP_SC_BIT && take) begin
      slot_q[n_q[SLOT_IDX_W-1:0]] <= {cnt_q, low_idx};
    end
  end

  assign out_valid_o   = out_valid_q;
  assign report_byte_o = out_byte_q;
  assign byte_index_o  = out_idx_q;
  assign boot_format_o = out_boot_q;
  assign last_byte_o   = out_last_q;
  assign write_error_o = out_err_q;

endmodule

/* rtl/hidkb_chk.sv */
module hidkb_chk import hidkb_pkg::*; #(
  parameter int unsigned BITMAP_BYTES = BITMAP_BYTES_DEF,
  parameter int unsigned BOOT_SLOTS   = BOOT_SLOTS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] report_byte_o,
  input logic [4:0] byte_index_o,
  input logic       boot_format_o,
  input logic       last_byte_o,
  input logic       write_error_o
);

  localparam logic [4:0] BM_LAST_IDX   = 5'(BITMAP_BYTES);
  localparam logic [4:0] BOOT_LAST_IDX = 5'(BOOT_SLOTS + 1);

  // one event at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an event is in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(report_byte_o)
      && $stable(byte_index_o) && $stable(last_byte_o))
    else $error("stalled output word changed");

  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_error_o |-> last_byte_o && byte_index_o == 5'd0
      && !boot_format_o && report_byte_o == 8'h00)
    else $error("malformed error word");

  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_byte_o && !write_error_o |->
      byte_index_o == (boot_format_o ? BOOT_LAST_IDX : BM_LAST_IDX))
    else $error("report run ended at the wrong index");

endmodule

bind hid_keyboard_report_engine_top hidkb_chk #(
  .BITMAP_BYTES (BITMAP_BYTES),
  .BOOT_SLOTS   (BOOT_SLOTS)
) u_hidkb_chk (.*);
